[rtl/core/swa_pkg.sv]
// Shared constants for the sliding window average core.
// No dependencies; imported by the core top level.
package swa_pkg;

  // Deepest window the history ring supports.
  localparam int MAX_WINDOW = 64;
  // Width of one signed sample.
  localparam int SAMPLE_BITS = 16;
  // Width of the window size register.
  localparam int CFG_BITS = 7;
  // Window size after reset.
  localparam logic [CFG_BITS-1:0] WINDOW_RESET = CFG_BITS'(5);

  // Ring pointer, sample count and running sum widths.
  localparam int PTR_BITS = $clog2(MAX_WINDOW);
  localparam int CNT_BITS = PTR_BITS + 1;
  localparam int SUM_BITS = SAMPLE_BITS + PTR_BITS;
  // Counter over the quotient bits of the serial divider.
  localparam int STEP_BITS = $clog2(SUM_BITS);

endpackage

[rtl/core/swa_ram.sv]
// Generic single-port-write, single-port-read RAM with a registered read.
// No dependencies; used for the sample history ring.
module swa_ram #(
  parameter int WIDTH = 16,
  parameter int DEPTH = 64
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  // Write port and registered read port.
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

[rtl/core/sliding_window_average_core.sv]
// Simple moving average over a signed Q1.15 sample stream.
// Depends on swa_pkg and swa_ram.

// Each accepted sample is written to a 64-entry history RAM, and a running sum of the
// last min(count, window) samples is updated by adding the new sample and subtracting
// the one that leaves the window, read from the RAM in the cycle before the update. The
// mean is the sum divided by the window size, truncated toward zero, produced by a
// bit-serial restoring divider that retires one quotient bit per cycle. Once the window
// is full a sample passes an update step, 22 divide steps and an output load, which
// waits while a held result fills the result register; only then is the next beat
// taken. Before the window is full the divider is skipped and the result is 0 with
// window_full low. The divider sets the throughput. After a write to the window size
// register the running sum is rebuilt from the RAM, and no sample is accepted until the
// rebuild has re-read the min(samples seen, window) newest samples. A window size of 0
// acts as 1, and values above 64 act as 64. The result register lets a new sample
// enter while a result waits.
module sliding_window_average_core
  import swa_pkg::*;
(
  input  logic                          clk,
  input  logic                          rst_n,
  // Sample input channel.
  input  logic                          in_valid,
  output logic                          in_stall,
  input  logic signed [SAMPLE_BITS-1:0] in_sample,
  // Result channel.
  output logic                          out_valid,
  input  logic                          out_stall,
  output logic signed [SAMPLE_BITS-1:0] out_average,
  output logic                          out_window_full,
  // Window size register.
  input  logic                          cfg_we,
  input  logic [CFG_BITS-1:0]           cfg_wdata
);

  typedef enum logic [2:0] {
    S_IDLE,
    S_UPD,
    S_DIV,
    S_FIN,
    S_REB
  } state_t;

  localparam int WIDE_BITS = CFG_BITS + CNT_BITS;

  // Control registers.
  state_t                state_r, state_nxt;
  logic [CFG_BITS-1:0]   win_r, win_nxt;
  logic                  reb_pend_r, reb_pend_nxt;
  logic [PTR_BITS-1:0]   wp_r, wp_nxt;
  logic [CNT_BITS-1:0]   cnt_r, cnt_nxt;
  logic [CNT_BITS-1:0]   reb_cnt_r, reb_cnt_nxt;
  logic                  acc_vld_r, acc_vld_nxt;
  logic [STEP_BITS-1:0]  step_r, step_nxt;
  logic                  out_valid_r, out_valid_nxt;
  logic signed [SUM_BITS-1:0] sum_r, sum_nxt;

  // Payload registers.
  logic signed [SAMPLE_BITS-1:0] x_r, x_nxt;
  logic                          full_r, full_nxt;
  logic                          neg_r, neg_nxt;
  logic [SUM_BITS-1:0]           div_r, div_nxt;
  logic [CNT_BITS-1:0]           rem_r, rem_nxt;
  logic signed [SAMPLE_BITS-1:0] out_avg_r, out_avg_nxt;
  logic                          out_full_r, out_full_nxt;

  // History RAM ports.
  logic                   ram_we;
  logic [PTR_BITS-1:0]    ram_raddr;
  logic [SAMPLE_BITS-1:0] ram_rdata;

  // Datapath helpers.
  logic [CNT_BITS-1:0]        w_eff;
  logic [CNT_BITS-1:0]        reb_len;
  logic [CNT_BITS-1:0]        cnt_inc;
  logic signed [SUM_BITS-1:0] old_ext;
  logic signed [SUM_BITS-1:0] x_ext;
  logic signed [SUM_BITS-1:0] sum_upd;
  logic [SUM_BITS-1:0]        sum_mag;
  logic [CNT_BITS:0]          trial;
  logic                       qbit;
  logic [SAMPLE_BITS-1:0]     q_mag;
  logic                       out_free;

  swa_ram #(
    .WIDTH(SAMPLE_BITS),
    .DEPTH(MAX_WINDOW)
  ) u_hist (
    .clk  (clk),
    .we   (ram_we),
    .waddr(wp_r),
    .wdata(x_r),
    .raddr(ram_raddr),
    .rdata(ram_rdata)
  );

  // Clamp the window register to the supported range.
  always_comb begin
    if (win_r == '0) begin
      w_eff = CNT_BITS'(1);
    end else if (WIDE_BITS'(win_r) > WIDE_BITS'(MAX_WINDOW)) begin
      w_eff = CNT_BITS'(MAX_WINDOW);
    end else begin
      w_eff = CNT_BITS'(win_r);
    end
  end

  // Number of stored samples the running sum covers.
  assign reb_len = (cnt_r < w_eff) ? cnt_r : w_eff;

  // Sign-extended sample values and the running sum update.
  assign old_ext = SUM_BITS'(signed'(ram_rdata));
  assign x_ext   = SUM_BITS'(x_r);
  assign cnt_inc = (cnt_r == CNT_BITS'(MAX_WINDOW)) ? cnt_r : cnt_r + CNT_BITS'(1);
  assign sum_upd = (cnt_r >= w_eff) ? (sum_r + x_ext - old_ext) : (sum_r + x_ext);
  assign sum_mag = sum_upd[SUM_BITS-1] ? SUM_BITS'(-sum_upd) : SUM_BITS'(sum_upd);

  // One restoring divide step.
  assign trial = {rem_r, div_r[SUM_BITS-1]};
  assign qbit  = (trial >= {1'b0, w_eff});
  assign q_mag = div_r[SAMPLE_BITS-1:0];

  assign out_free = !out_valid_r || !out_stall;

  // Read address: the sample leaving the window, or the rebuild walk.
  always_comb begin
    if (state_r == S_REB) begin
      ram_raddr = wp_r - PTR_BITS'(1) - reb_cnt_r[PTR_BITS-1:0];
    end else begin
      ram_raddr = wp_r - w_eff[PTR_BITS-1:0];
    end
  end

  assign ram_we = (state_r == S_UPD);

  // Next-state and datapath logic.
  always_comb begin
    state_nxt     = state_r;
    win_nxt       = win_r;
    reb_pend_nxt  = reb_pend_r;
    wp_nxt        = wp_r;
    cnt_nxt       = cnt_r;
    reb_cnt_nxt   = reb_cnt_r;
    acc_vld_nxt   = 1'b0;
    step_nxt      = step_r;
    sum_nxt       = sum_r;
    x_nxt         = x_r;
    full_nxt      = full_r;
    neg_nxt       = neg_r;
    div_nxt       = div_r;
    rem_nxt       = rem_r;
    out_avg_nxt   = out_avg_r;
    out_full_nxt  = out_full_r;
    out_valid_nxt = out_valid_r && out_stall;

    if (cfg_we) begin
      win_nxt      = cfg_wdata;
      reb_pend_nxt = 1'b1;
    end

    case (state_r)
      S_IDLE: begin
        if (reb_pend_r) begin
          reb_pend_nxt = cfg_we;
          reb_cnt_nxt  = '0;
          sum_nxt      = '0;
          state_nxt    = S_REB;
        end else if (in_valid && !cfg_we) begin
          x_nxt     = in_sample;
          state_nxt = S_UPD;
        end
      end
      S_UPD: begin
        // Write the sample, roll the sum and set up the divider.
        wp_nxt    = wp_r + PTR_BITS'(1);
        cnt_nxt   = cnt_inc;
        sum_nxt   = sum_upd;
        full_nxt  = (cnt_inc >= w_eff);
        neg_nxt   = sum_upd[SUM_BITS-1];
        div_nxt   = sum_mag;
        rem_nxt   = '0;
        step_nxt  = STEP_BITS'(SUM_BITS - 1);
        state_nxt = (cnt_inc >= w_eff) ? S_DIV : S_FIN;
      end
      S_DIV: begin
        if (qbit) begin
          rem_nxt = CNT_BITS'(trial - {1'b0, w_eff});
        end else begin
          rem_nxt = CNT_BITS'(trial);
        end
        div_nxt = {div_r[SUM_BITS-2:0], qbit};
        step_nxt = step_r - STEP_BITS'(1);
        if (step_r == '0) begin
          state_nxt = S_FIN;
        end
      end
      S_FIN: begin
        // Load the result register once it is free.
        if (out_free) begin
          out_valid_nxt = 1'b1;
          out_full_nxt  = full_r;
          if (!full_r) begin
            out_avg_nxt = '0;
          end else if (neg_r) begin
            out_avg_nxt = signed'(-q_mag);
          end else begin
            out_avg_nxt = signed'(q_mag);
          end
          state_nxt = S_IDLE;
        end
      end
      S_REB: begin
        // Re-sum the newest samples; read data arrives in the following cycle.
        if (acc_vld_r) begin
          sum_nxt = sum_r + old_ext;
        end
        if (reb_cnt_r < reb_len) begin
          reb_cnt_nxt = reb_cnt_r + CNT_BITS'(1);
          acc_vld_nxt = 1'b1;
        end else if (!acc_vld_r) begin
          state_nxt = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  // Control state with synchronous reset.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      win_r       <= WINDOW_RESET;
      reb_pend_r  <= 1'b0;
      wp_r        <= '0;
      cnt_r       <= '0;
      reb_cnt_r   <= '0;
      acc_vld_r   <= 1'b0;
      step_r      <= '0;
      out_valid_r <= 1'b0;
      sum_r       <= '0;
    end else begin
      state_r     <= state_nxt;
      win_r       <= win_nxt;
      reb_pend_r  <= reb_pend_nxt;
      wp_r        <= wp_nxt;
      cnt_r       <= cnt_nxt;
      reb_cnt_r   <= reb_cnt_nxt;
      acc_vld_r   <= acc_vld_nxt;
      step_r      <= step_nxt;
      out_valid_r <= out_valid_nxt;
      sum_r       <= sum_nxt;
    end
  end

  // Payload registers.
  always_ff @(posedge clk) begin
    x_r        <= x_nxt;
    full_r     <= full_nxt;
    neg_r      <= neg_nxt;
    div_r      <= div_nxt;
    rem_r      <= rem_nxt;
    out_avg_r  <= out_avg_nxt;
    out_full_r <= out_full_nxt;
  end

  // A beat is taken only in idle with no rebuild pending and no register write.
  assign in_stall        = (state_r != S_IDLE) || reb_pend_r || cfg_we;
  assign out_valid       = out_valid_r;
  assign out_average     = out_avg_r;
  assign out_window_full = out_full_r;

endmodule

[test/tb.sv]
// Self-checking testbench for the sliding window average core.
// Depends on swa_pkg and the core RTL; mirrors the moving average in a local predictor.
`timescale 1ns / 100ps

module tb;
  import swa_pkg::*;

  localparam int CYCLE_LIMIT = 200_000;
  localparam int MAX_REPORTS = 10;
  // Idle time at the end, long enough to cover a full-window result with room to spare.
  localparam int SETTLE_CYCLES = 40;

  typedef struct {
    logic signed [SAMPLE_BITS-1:0] average;
    logic                          window_full;
  } mean_t;

  logic                          clk;
  logic                          rst_n;
  logic                          in_valid;
  logic                          in_stall;
  logic signed [SAMPLE_BITS-1:0] in_sample;
  logic                          out_valid;
  logic                          out_stall;
  logic signed [SAMPLE_BITS-1:0] out_average;
  logic                          out_window_full;
  logic                          cfg_we;
  logic [CFG_BITS-1:0]           cfg_wdata;

  // Predictor state: sample ring, pointer, saturating count and window register.
  logic signed [SAMPLE_BITS-1:0] ring [MAX_WINDOW];
  logic [PTR_BITS-1:0]           ring_ptr = '0;
  int                            seen_count = 0;
  logic [CFG_BITS-1:0]           window_reg = WINDOW_RESET;
  mean_t                         expected_means[$];

  int error_count = 0;
  int cycle_count = 0;
  int send_idle_pct = 0;
  int stall_pct = 0;
  int hold_request = 0;
  int hold_left = 0;

  sliding_window_average_core dut (
    .clk             (clk),
    .rst_n           (rst_n),
    .in_valid        (in_valid),
    .in_stall        (in_stall),
    .in_sample       (in_sample),
    .out_valid       (out_valid),
    .out_stall       (out_stall),
    .out_average     (out_average),
    .out_window_full (out_window_full),
    .cfg_we          (cfg_we),
    .cfg_wdata       (cfg_wdata)
  );

  // 20 ns clock.
  always begin
    clk = 1'b0;
    #10;
    clk = 1'b1;
    #10;
  end

  // Run limit.
  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("Verification failed");
      $finish;
    end
  end

  // Appends one sample and queues the mean of the most recent window.
  function automatic void predict_mean(logic signed [SAMPLE_BITS-1:0] value);
    int    span;
    int    total;
    int    k;
    mean_t m;
    if (window_reg == 0) begin
      span = 1;
    end else if (window_reg > MAX_WINDOW) begin
      span = MAX_WINDOW;
    end else begin
      span = int'(window_reg);
    end
    ring[ring_ptr] = value;
    ring_ptr = ring_ptr + 1'b1;
    if (seen_count < MAX_WINDOW) seen_count++;
    m.average = '0;
    m.window_full = 1'b0;
    if (seen_count >= span) begin
      total = 0;
      for (k = 1; k <= span; k++) begin
        total += ring[PTR_BITS'(int'(ring_ptr) - k)];
      end
      // Integer division truncates toward zero, as the block does.
      m.average = SAMPLE_BITS'(total / span);
      m.window_full = 1'b1;
    end
    expected_means = {expected_means, m};
  endfunction

  // Tracks register writes and accepted input beats.
  always @(posedge clk) begin
    if (rst_n) begin
      if (cfg_we) window_reg = cfg_wdata;
      if (in_valid && !in_stall) predict_mean(in_sample);
    end
  end

  // Compares each result beat with the oldest expected mean.
  always @(posedge clk) begin : check_means
    mean_t want;
    if (rst_n && out_valid && !out_stall) begin
      if (expected_means.size() == 0) begin
        error_count++;
        if (error_count <= MAX_REPORTS)
          $display("Unexpected result beat: average %0d window_full %0b",
                   out_average, out_window_full);
      end else begin
        want = expected_means.pop_front();
        if (out_average !== want.average || out_window_full !== want.window_full) begin
          error_count++;
          if (error_count <= MAX_REPORTS)
            $display("Mismatch: expected average %0d full %0b, got average %0d full %0b",
                     want.average, want.window_full, out_average, out_window_full);
        end
      end
    end
  end

  // Receiver side: random stalls, or a long hold-off when a test asks for one.
  always @(posedge clk) begin
    if (hold_request != 0) begin
      hold_left = hold_request;
      hold_request = 0;
    end
    if (hold_left != 0) begin
      out_stall <= 1'b1;
      hold_left--;
    end else begin
      out_stall <= ($urandom_range(99) < stall_pct);
    end
  end

  // Sends one sample beat, with random idle cycles ahead of it.
  task automatic send_sample(input logic signed [SAMPLE_BITS-1:0] value);
    if ($urandom_range(99) < send_idle_pct) begin
      in_valid <= 1'b0;
      do @(posedge clk); while ($urandom_range(99) < send_idle_pct);
    end
    in_valid <= 1'b1;
    in_sample <= value;
    do @(posedge clk); while (in_stall);
  endtask

  // Stops sending and waits until every expected result has arrived.
  task automatic wait_drained();
    in_valid <= 1'b0;
    @(posedge clk);
    while (expected_means.size() != 0) @(posedge clk);
  endtask

  task automatic write_window(input logic [CFG_BITS-1:0] size);
    wait_drained();
    cfg_we <= 1'b1;
    cfg_wdata <= size;
    @(posedge clk);
    cfg_we <= 1'b0;
  endtask

  function automatic logic signed [SAMPLE_BITS-1:0] random_sample();
    case ($urandom_range(9))
      0: return 16'sh7fff;
      1: return 16'sh8000;
      2, 3: return SAMPLE_BITS'(int'($urandom_range(64)) - 32);
      default: return SAMPLE_BITS'($urandom);
    endcase
  endfunction

  // Window sizes weighted toward the limits, including the clamped values.
  function automatic logic [CFG_BITS-1:0] random_window();
    case ($urandom_range(7))
      0: return CFG_BITS'(0);
      1: return CFG_BITS'(1);
      2: return CFG_BITS'(MAX_WINDOW);
      3: return '1;
      4: return CFG_BITS'($urandom_range(MAX_WINDOW + 1, 126));
      default: return CFG_BITS'($urandom_range(2, MAX_WINDOW - 1));
    endcase
  endfunction

  // Reset window of five: filling up, full-scale values of both signs, and small ones.
  task automatic test_reset_window();
    repeat (5) send_sample(16'sh7fff);
    repeat (5) send_sample(16'sh8000);
    send_sample(-16'sd1);
    send_sample(16'sd1);
    send_sample(16'sd0);
    wait_drained();
  endtask

  // Size zero acts as one, sizes above the ring depth act as the depth.
  task automatic test_window_limits();
    write_window(CFG_BITS'(0));
    send_sample(16'sh8000);
    send_sample(16'sh7fff);
    // Fewer samples than the clamped window have arrived, so the result is not full.
    write_window('1);
    send_sample(16'sd1);
    send_sample(-16'sd1);
    write_window(CFG_BITS'(1));
    send_sample(16'sh5a5a);
    wait_drained();
  endtask

  // Random samples with a window change in the middle of the stream.
  task automatic test_random_traffic(input int count, input int idle_pct, input int stall_rate);
    int i;
    send_idle_pct = idle_pct;
    stall_pct = stall_rate;
    write_window(random_window());
    for (i = 0; i < count; i++) begin
      if (i == count / 2) write_window(random_window());
      send_sample(random_sample());
    end
    wait_drained();
  endtask

  // The receiver holds off long enough for the core to fill and stall its input.
  task automatic test_backpressure();
    int i;
    send_idle_pct = 0;
    stall_pct = 0;
    write_window(CFG_BITS'(MAX_WINDOW));
    hold_request = 400;
    for (i = 0; i < 30; i++) send_sample(random_sample());
    wait_drained();
  endtask

  initial begin
    rst_n <= 1'b0;
    in_valid <= 1'b0;
    in_sample <= '0;
    cfg_we <= 1'b0;
    cfg_wdata <= '0;
    out_stall <= 1'b0;
    repeat (3) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    test_reset_window();
    test_window_limits();
    test_random_traffic(100, 0, 0);
    test_random_traffic(90, 71, 0);
    test_random_traffic(90, 0, 71);
    test_random_traffic(90, 15, 15);
    test_backpressure();

    wait_drained();
    repeat (SETTLE_CYCLES) @(posedge clk);
    if (error_count == 0 && expected_means.size() == 0) begin
      $display("Verification passed");
    end else begin
      $display("Verification failed");
    end
    $finish;
  end

endmodule
